### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, suspended while reset is asserted.
`define CHK_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also runs through reset.
`define CHK_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hsvrgb_pkg.sv
// Package: widths, constants, sector codes and the mid-pipeline struct.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W    = 15;   // input hue, signed, 1/16 degree
    localparam int SAT_W    = 14;   // input saturation / value, signed Q12
    localparam int Q_W      = 13;   // clamped Q12, 0..4096
    localparam int Q_FRAC   = 12;
    localparam int HUE_RW   = 13;   // reduced hue, 0..5759
    localparam int HSUM_W   = 17;   // hue plus wrap offset
    localparam int DIST_W   = 10;   // 0..960
    localparam int C24_W    = 25;   // v*s, Q24, up to 2^24
    localparam int P_W      = 35;   // c24 * xdist
    localparam int NX_W     = 34;   // x-channel numerator, up to 960*2^24
    localparam int CH_W     = 8;

    localparam int HUE_FULL   = 5760;  // 360 degrees
    localparam int HUE_SECTOR = 960;   // 60 degrees
    localparam int Q12_ONE    = 4096;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [Q_W-1:0]    val;
        logic [C24_W-1:0]  c24;
        logic [DIST_W-1:0] xdist;
        t_sector           sector;
    } t_mid;

endpackage

### rtl/hsvrgb_if.sv
// Channel interfaces: HSV input transactions and RGB result transactions.
`timescale 1ns / 1ps

interface hsvrgb_hsv_if;
    logic                                valid;
    logic                                ready;
    logic signed [hsvrgb_pkg::HUE_W-1:0] hue;
    logic signed [hsvrgb_pkg::SAT_W-1:0] saturation;
    logic signed [hsvrgb_pkg::SAT_W-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_rgb_if;
    logic                           valid;
    logic                           ready;
    logic [hsvrgb_pkg::CH_W-1:0]    red;
    logic [hsvrgb_pkg::CH_W-1:0]    green;
    logic [hsvrgb_pkg::CH_W-1:0]    blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/hsvrgb_front.sv
// Front stages: clamp and hue wrap, then sector, distance and chroma product.
`timescale 1ns / 1ps

module hsvrgb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hsvrgb_hsv_if.sink         i_hsv,
    output logic               o_mid_valid,
    input  logic               i_mid_ready,
    output hsvrgb_pkg::t_mid   o_mid
);

    logic en1, en2;

    // stage 1
    logic                           r_vld1;
    logic [hsvrgb_pkg::HUE_RW-1:0]  r_hue1;
    logic [hsvrgb_pkg::Q_W-1:0]     r_sat1;
    logic [hsvrgb_pkg::Q_W-1:0]     r_val1;

    logic signed [hsvrgb_pkg::HSUM_W-1:0] w_off;
    logic signed [hsvrgb_pkg::HSUM_W-1:0] w_hsum;
    logic [hsvrgb_pkg::HUE_RW-1:0]        n_hue1;
    logic [hsvrgb_pkg::Q_W-1:0]           n_sat1;
    logic [hsvrgb_pkg::Q_W-1:0]           n_val1;

    // stage 2
    logic                           r_vld2;
    hsvrgb_pkg::t_mid               r_mid2;

    hsvrgb_pkg::t_sector            w_sec;
    logic [hsvrgb_pkg::HUE_RW-1:0]  w_base;
    logic [hsvrgb_pkg::DIST_W-1:0]  w_rem;
    logic [2*hsvrgb_pkg::Q_W-1:0]   w_prod;
    hsvrgb_pkg::t_mid               n_mid2;

    function automatic logic [hsvrgb_pkg::Q_W-1:0] clamp_q12(
        input logic signed [hsvrgb_pkg::SAT_W-1:0] x
    );
        logic [hsvrgb_pkg::Q_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > hsvrgb_pkg::SAT_W'(hsvrgb_pkg::Q12_ONE)) begin
            res = hsvrgb_pkg::Q_W'(hsvrgb_pkg::Q12_ONE);
        end else begin
            res = x[hsvrgb_pkg::Q_W-1:0];
        end
        return res;
    endfunction

    assign en2 = !r_vld2 || i_mid_ready;
    assign en1 = !r_vld1 || en2;
    assign i_hsv.ready = en1;

    // hue covers -16384..16383: one of six wrap offsets lands it in 0..5759
    always_comb begin
        if (i_hsv.hue >= hsvrgb_pkg::HUE_W'(2 * hsvrgb_pkg::HUE_FULL)) begin
            w_off = hsvrgb_pkg::HSUM_W'(-2 * hsvrgb_pkg::HUE_FULL);
        end else if (i_hsv.hue >= hsvrgb_pkg::HUE_W'(hsvrgb_pkg::HUE_FULL)) begin
            w_off = hsvrgb_pkg::HSUM_W'(-hsvrgb_pkg::HUE_FULL);
        end else if (i_hsv.hue >= 0) begin
            w_off = '0;
        end else if (i_hsv.hue >= hsvrgb_pkg::HUE_W'(-hsvrgb_pkg::HUE_FULL)) begin
            w_off = hsvrgb_pkg::HSUM_W'(hsvrgb_pkg::HUE_FULL);
        end else if (i_hsv.hue >= hsvrgb_pkg::HUE_W'(-2 * hsvrgb_pkg::HUE_FULL)) begin
            w_off = hsvrgb_pkg::HSUM_W'(2 * hsvrgb_pkg::HUE_FULL);
        end else begin
            w_off = hsvrgb_pkg::HSUM_W'(3 * hsvrgb_pkg::HUE_FULL);
        end
        w_hsum = hsvrgb_pkg::HSUM_W'(i_hsv.hue) + w_off;
        n_hue1 = w_hsum[hsvrgb_pkg::HUE_RW-1:0];
        n_sat1 = clamp_q12(i_hsv.saturation);
        n_val1 = clamp_q12(i_hsv.brightness);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (en1) begin
            r_vld1 <= i_hsv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hue1 <= n_hue1;
            r_sat1 <= n_sat1;
            r_val1 <= n_val1;
        end
    end

    // sector, offset within sector, and distance from the sector's x peak
    always_comb begin
        if (r_hue1 >= hsvrgb_pkg::HUE_RW'(5 * hsvrgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsvrgb_pkg::SEC_M_TO_R;
            w_base = hsvrgb_pkg::HUE_RW'(5 * hsvrgb_pkg::HUE_SECTOR);
        end else if (r_hue1 >= hsvrgb_pkg::HUE_RW'(4 * hsvrgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsvrgb_pkg::SEC_B_TO_M;
            w_base = hsvrgb_pkg::HUE_RW'(4 * hsvrgb_pkg::HUE_SECTOR);
        end else if (r_hue1 >= hsvrgb_pkg::HUE_RW'(3 * hsvrgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsvrgb_pkg::SEC_C_TO_B;
            w_base = hsvrgb_pkg::HUE_RW'(3 * hsvrgb_pkg::HUE_SECTOR);
        end else if (r_hue1 >= hsvrgb_pkg::HUE_RW'(2 * hsvrgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsvrgb_pkg::SEC_G_TO_C;
            w_base = hsvrgb_pkg::HUE_RW'(2 * hsvrgb_pkg::HUE_SECTOR);
        end else if (r_hue1 >= hsvrgb_pkg::HUE_RW'(hsvrgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsvrgb_pkg::SEC_Y_TO_G;
            w_base = hsvrgb_pkg::HUE_RW'(hsvrgb_pkg::HUE_SECTOR);
        end else begin
            w_sec  = hsvrgb_pkg::SEC_R_TO_Y;
            w_base = '0;
        end
        w_rem  = hsvrgb_pkg::DIST_W'(r_hue1 - w_base);
        w_prod = r_sat1 * r_val1;

        n_mid2.val    = r_val1;
        n_mid2.c24    = w_prod[hsvrgb_pkg::C24_W-1:0];
        n_mid2.sector = w_sec;
        // odd sectors: x falls with rem; even sectors: x rises with rem
        if (w_sec[0]) begin
            n_mid2.xdist = w_rem;
        end else begin
            n_mid2.xdist = hsvrgb_pkg::DIST_W'(hsvrgb_pkg::HUE_SECTOR) - w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (en2) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_mid2 <= n_mid2;
        end
    end

    assign o_mid_valid = r_vld2;
    assign o_mid       = r_mid2;

endmodule

### rtl/hsvrgb_back.sv
// Back stages: x-channel product, channel scaling, sector ordering to RGB.
`timescale 1ns / 1ps

module hsvrgb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_valid,
    output logic               o_mid_ready,
    input  hsvrgb_pkg::t_mid   i_mid,
    hsvrgb_rgb_if.source       o_rgb
);

    logic en3, en4, en5;

    // stage 3
    logic                           r_vld3;
    logic [hsvrgb_pkg::Q_W-1:0]     r_val3;
    logic [hsvrgb_pkg::P_W-1:0]     r_p3;
    logic [hsvrgb_pkg::C24_W-1:0]   r_mb3;
    hsvrgb_pkg::t_sector            r_sec3;
    logic [hsvrgb_pkg::P_W-1:0]     n_p3;
    logic [hsvrgb_pkg::C24_W-1:0]   n_mb3;

    // stage 4
    logic                           r_vld4;
    logic [hsvrgb_pkg::NX_W-1:0]    r_nx4;
    logic [hsvrgb_pkg::CH_W-1:0]    r_cc4;
    logic [hsvrgb_pkg::CH_W-1:0]    r_mm4;
    hsvrgb_pkg::t_sector            r_sec4;
    logic [hsvrgb_pkg::P_W-1:0]     w_vk;
    logic [hsvrgb_pkg::P_W-1:0]     w_nx;
    logic [hsvrgb_pkg::Q_W+8-1:0]   w_c255;
    logic [hsvrgb_pkg::C24_W+8-1:0] w_m255;
    logic [hsvrgb_pkg::NX_W-1:0]    n_nx4;
    logic [hsvrgb_pkg::CH_W-1:0]    n_cc4;
    logic [hsvrgb_pkg::CH_W-1:0]    n_mm4;

    // stage 5
    logic                           r_vld5;
    logic [hsvrgb_pkg::CH_W-1:0]    r_red;
    logic [hsvrgb_pkg::CH_W-1:0]    r_green;
    logic [hsvrgb_pkg::CH_W-1:0]    r_blue;
    logic [hsvrgb_pkg::NX_W+4-1:0]  w_x17;
    logic [hsvrgb_pkg::CH_W-1:0]    w_xx;
    logic [hsvrgb_pkg::CH_W-1:0]    n_red;
    logic [hsvrgb_pkg::CH_W-1:0]    n_green;
    logic [hsvrgb_pkg::CH_W-1:0]    n_blue;

    assign en5 = !r_vld5 || o_rgb.ready;
    assign en4 = !r_vld4 || en5;
    assign en3 = !r_vld3 || en4;
    assign o_mid_ready = en3;

    // x-channel numerator is 960*4096*v - c24*xdist; m part is 4096*v - c24
    always_comb begin
        n_p3  = hsvrgb_pkg::P_W'(i_mid.c24) * hsvrgb_pkg::P_W'(i_mid.xdist);
        n_mb3 = {i_mid.val, {hsvrgb_pkg::Q_FRAC{1'b0}}} - i_mid.c24;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (en3) begin
            r_vld3 <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_val3 <= i_mid.val;
            r_p3   <= n_p3;
            r_mb3  <= n_mb3;
            r_sec3 <= i_mid.sector;
        end
    end

    // 255/960 = 17/64, so channel = floor(17*num / 2^30) over 960*2^24
    always_comb begin
        // v * 960 * 4096 = v * (2^22 - 2^18)
        w_vk   = (hsvrgb_pkg::P_W'(r_val3) << 22) - (hsvrgb_pkg::P_W'(r_val3) << 18);
        w_nx   = w_vk - r_p3;
        n_nx4  = w_nx[hsvrgb_pkg::NX_W-1:0];
        w_c255 = {r_val3, 8'b0} - (hsvrgb_pkg::Q_W+8)'(r_val3);
        n_cc4  = w_c255[19:12];
        w_m255 = {r_mb3, 8'b0} - (hsvrgb_pkg::C24_W+8)'(r_mb3);
        n_mm4  = w_m255[31:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (en4) begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_nx4  <= n_nx4;
            r_cc4  <= n_cc4;
            r_mm4  <= n_mm4;
            r_sec4 <= r_sec3;
        end
    end

    always_comb begin
        w_x17 = {r_nx4, 4'b0} + (hsvrgb_pkg::NX_W+4)'(r_nx4);
        w_xx  = w_x17[hsvrgb_pkg::NX_W+3 -: hsvrgb_pkg::CH_W];
        case (r_sec4)
            hsvrgb_pkg::SEC_R_TO_Y: begin
                n_red = r_cc4; n_green = w_xx;  n_blue = r_mm4;
            end
            hsvrgb_pkg::SEC_Y_TO_G: begin
                n_red = w_xx;  n_green = r_cc4; n_blue = r_mm4;
            end
            hsvrgb_pkg::SEC_G_TO_C: begin
                n_red = r_mm4; n_green = r_cc4; n_blue = w_xx;
            end
            hsvrgb_pkg::SEC_C_TO_B: begin
                n_red = r_mm4; n_green = w_xx;  n_blue = r_cc4;
            end
            hsvrgb_pkg::SEC_B_TO_M: begin
                n_red = w_xx;  n_green = r_mm4; n_blue = r_cc4;
            end
            default: begin
                n_red = r_cc4; n_green = r_mm4; n_blue = w_xx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (en5) begin
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_vld5;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

endmodule

### rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter.
`timescale 1ns / 1ps
//
// i_hsv takes one colour per transaction: hue in 1/16 degree (any 15-bit value,
// wrapped into 0..360 degrees), saturation and brightness in Q12 (clamped to
// 0..1.0). o_rgb gives one 8-bit red/green/blue triple per input transaction,
// in input order.
// The datapath is a five-stage pipeline: hue wrap and clamp, sector and chroma
// multiply, x-channel multiply, channel scaling, sector ordering. The x-channel
// multiply is 25x10. One transaction per cycle is sustained while o_rgb.ready
// stays high, that is while the receiver takes every result.
// Each stage holds its own valid bit and advances when the next one is empty
// or moving, so bubbles close up; i_hsv.ready only drops once all five stages
// hold results that the receiver has not taken. A stalled output holds its
// value. Synchronous reset clears the valid bits only; no setup is needed.
//

module hsv_to_rgb_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsvrgb_hsv_if.sink    i_hsv,
    hsvrgb_rgb_if.source  o_rgb
);

    logic              w_mid_valid;
    logic              w_mid_ready;
    hsvrgb_pkg::t_mid  w_mid;

    hsvrgb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hsv       (i_hsv),
        .o_mid_valid (w_mid_valid),
        .i_mid_ready (w_mid_ready),
        .o_mid       (w_mid)
    );

    hsvrgb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (w_mid_valid),
        .o_mid_ready (w_mid_ready),
        .i_mid       (w_mid),
        .o_rgb       (o_rgb)
    );

endmodule

### rtl/hsvrgb_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsvrgb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic [hsvrgb_pkg::SAT_W-1:0]       i_in_brightness,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [hsvrgb_pkg::CH_W-1:0]        i_out_red,
    input logic [hsvrgb_pkg::CH_W-1:0]        i_out_green,
    input logic [hsvrgb_pkg::CH_W-1:0]        i_out_blue
);

    logic w_in_acc;
    logic w_in_dark;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_in_dark = i_in_brightness[hsvrgb_pkg::SAT_W-1];

    `CHK_ASSERT_NR(a_reset_clears, i_clk, $past(!i_rst_n) |-> !i_out_valid, "output valid after reset")

    `CHK_ASSERT(a_ready_follows, i_clk, i_rst_n, i_out_ready |-> i_in_ready, "input stalled while output drains")

    `CHK_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue), "stalled result changed")

    // negative brightness clamps to black, which the output shows when nothing stalls
    `CHK_ASSERT(a_black_latency, i_clk, i_rst_n, w_in_acc && w_in_dark && i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid && i_out_red == 0 && i_out_green == 0 && i_out_blue == 0, "dark input not black at latency")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_hsv.valid),
    .i_in_ready      (i_hsv.ready),
    .i_in_brightness (i_hsv.brightness),
    .i_out_valid     (o_rgb.valid),
    .i_out_ready     (o_rgb.ready),
    .i_out_red       (o_rgb.red),
    .i_out_green     (o_rgb.green),
    .i_out_blue      (o_rgb.blue)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for hsv_to_rgb_converter: directed and random colors checked against an RGB predictor.

module tb_top;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 20;      // five-stage pipeline plus margin
    // ~2000 transactions with random input gaps and output stalls; limit set ~4x over the worst case
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [hsvrgb_pkg::CH_W-1:0] red;
        logic [hsvrgb_pkg::CH_W-1:0] green;
        logic [hsvrgb_pkg::CH_W-1:0] blue;
    } t_rgb;

    typedef struct {
        logic signed [hsvrgb_pkg::HUE_W-1:0] hue;
        logic signed [hsvrgb_pkg::SAT_W-1:0] sat;
        logic signed [hsvrgb_pkg::SAT_W-1:0] bri;
        t_rgb                                rgb;
    } t_color_txn;

    logic i_clk;
    logic i_rst_n;

    hsvrgb_hsv_if hsv_ch ();
    hsvrgb_rgb_if rgb_ch ();

    hsv_to_rgb_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsv   (hsv_ch),
        .o_rgb   (rgb_ch)
    );

    t_color_txn pending_rgb[$];
    t_color_txn accepted_color;
    t_color_txn oldest_color;
    int         mismatches = 0;
    int         cycles = 0;
    bit         idle_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic longint unsigned q12_clamp(
        input logic signed [hsvrgb_pkg::SAT_W-1:0] raw
    );
        if (raw < 0)
            return 0;
        if (raw > hsvrgb_pkg::Q12_ONE)
            return hsvrgb_pkg::Q12_ONE;
        return longint'(raw);
    endfunction

    // numerator over 960 * 2^24 -> truncated 8-bit channel
    function automatic logic [hsvrgb_pkg::CH_W-1:0] channel_from_num(
        input longint unsigned num
    );
        longint unsigned den;
        den = longint'(hsvrgb_pkg::HUE_SECTOR) << 24;
        return hsvrgb_pkg::CH_W'((num * 255) / den);
    endfunction

    function automatic t_rgb rgb_from_hsv(input logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
                                          input logic signed [hsvrgb_pkg::SAT_W-1:0] sat,
                                          input logic signed [hsvrgb_pkg::SAT_W-1:0] bri);
        int                  h;
        int unsigned         hu;
        int unsigned         f;
        int unsigned         xdist;
        longint unsigned     s;
        longint unsigned     v;
        longint unsigned     c24;
        longint unsigned     cn;
        longint unsigned     xn;
        longint unsigned     mn;
        longint unsigned     r;
        longint unsigned     g;
        longint unsigned     b;
        hsvrgb_pkg::t_sector sec;
        t_rgb                rgb;

        h = int'(hue) % hsvrgb_pkg::HUE_FULL;
        if (h < 0)
            h += hsvrgb_pkg::HUE_FULL;
        hu = h;
        s = q12_clamp(sat);
        v = q12_clamp(bri);

        c24   = v * s;
        f     = hu % (2 * hsvrgb_pkg::HUE_SECTOR);
        xdist = (f >= hsvrgb_pkg::HUE_SECTOR) ? (f - hsvrgb_pkg::HUE_SECTOR)
                                              : (hsvrgb_pkg::HUE_SECTOR - f);
        cn    = c24 * hsvrgb_pkg::HUE_SECTOR;
        xn    = c24 * (hsvrgb_pkg::HUE_SECTOR - xdist);
        mn    = (v * hsvrgb_pkg::Q12_ONE - c24) * hsvrgb_pkg::HUE_SECTOR;

        sec = hsvrgb_pkg::t_sector'(hu / hsvrgb_pkg::HUE_SECTOR);
        case (sec)
            hsvrgb_pkg::SEC_R_TO_Y: begin r = cn; g = xn; b = 0;  end
            hsvrgb_pkg::SEC_Y_TO_G: begin r = xn; g = cn; b = 0;  end
            hsvrgb_pkg::SEC_G_TO_C: begin r = 0;  g = cn; b = xn; end
            hsvrgb_pkg::SEC_C_TO_B: begin r = 0;  g = xn; b = cn; end
            hsvrgb_pkg::SEC_B_TO_M: begin r = xn; g = 0;  b = cn; end
            default:                begin r = cn; g = 0;  b = xn; end
        endcase

        rgb.red   = channel_from_num(r + mn);
        rgb.green = channel_from_num(g + mn);
        rgb.blue  = channel_from_num(b + mn);
        return rgb;
    endfunction

    // ---------------- monitor / checker ----------------

    function void log_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endfunction

    // input and output transactions handled in one process, input first, so ordering holds even for a same-cycle result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hsv_ch.valid && hsv_ch.ready) begin
                accepted_color.hue = hsv_ch.hue;
                accepted_color.sat = hsv_ch.saturation;
                accepted_color.bri = hsv_ch.brightness;
                accepted_color.rgb = rgb_from_hsv(hsv_ch.hue, hsv_ch.saturation,
                                                  hsv_ch.brightness);
                pending_rgb.push_back(accepted_color);
            end
            if (rgb_ch.valid && rgb_ch.ready) begin
                if (pending_rgb.size() == 0) begin
                    log_failure($sformatf("unexpected rgb %0d/%0d/%0d",
                                          rgb_ch.red, rgb_ch.green, rgb_ch.blue));
                end else begin
                    oldest_color = pending_rgb.pop_front();
                    if (rgb_ch.red !== oldest_color.rgb.red
                        || rgb_ch.green !== oldest_color.rgb.green
                        || rgb_ch.blue !== oldest_color.rgb.blue)
                        log_failure($sformatf(
                            "hsv %0d/%0d/%0d: expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                            oldest_color.hue, oldest_color.sat, oldest_color.bri,
                            oldest_color.rgb.red, oldest_color.rgb.green,
                            oldest_color.rgb.blue,
                            rgb_ch.red, rgb_ch.green, rgb_ch.blue));
                end
            end
        end
    end

    // ---------------- result sink ----------------

    initial begin
        rgb_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                rgb_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            rgb_ch.ready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------

    // returns at the edge where the transaction was taken; valid stays high
    task automatic send_hsv(input logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
                            input logic signed [hsvrgb_pkg::SAT_W-1:0] sat,
                            input logic signed [hsvrgb_pkg::SAT_W-1:0] bri);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            hsv_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= hue;
        hsv_ch.saturation <= sat;
        hsv_ch.brightness <= bri;
        do @(posedge i_clk); while (!hsv_ch.ready);
    endtask

    function automatic logic signed [hsvrgb_pkg::HUE_W-1:0] random_hue();
        case ($urandom_range(0, 5))
            0, 1, 2: return hsvrgb_pkg::HUE_W'(int'($urandom_range(0, 17279))
                                               - hsvrgb_pkg::HUE_FULL);
            3:       return hsvrgb_pkg::HUE_W'($urandom);
            // near a sector boundary, wrapping points included
            default: return hsvrgb_pkg::HUE_W'(
                         hsvrgb_pkg::HUE_SECTOR * int'($urandom_range(0, 11))
                         + int'($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    function automatic logic signed [hsvrgb_pkg::SAT_W-1:0] random_q12();
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: return hsvrgb_pkg::SAT_W'($urandom_range(0, hsvrgb_pkg::Q12_ONE));
            5:             return ($urandom_range(0, 1) != 0)
                                  ? hsvrgb_pkg::SAT_W'(hsvrgb_pkg::Q12_ONE) : '0;
            6:             return hsvrgb_pkg::SAT_W'($urandom);
            default:       return hsvrgb_pkg::SAT_W'(int'($urandom_range(0, 12287))
                                                     - hsvrgb_pkg::Q12_ONE);
        endcase
    endfunction

    task automatic test_hue_wrap();
        send_hsv(-16384, 4096, 4096);
        send_hsv(16383, 4096, 4096);
        send_hsv(-5760, 3000, 3500);
        send_hsv(11519, 3000, 3500);
        send_hsv(5760, 2048, 4096);
        send_hsv(-1, 4096, 2048);
    endtask

    task automatic test_sat_val_clamp();
        send_hsv(700, -8192, 8191);
        send_hsv(2000, 8191, -8192);
        send_hsv(3100, 4097, 4096);
        send_hsv(4500, -1, 2048);
        send_hsv(5000, 0, 4096);
        send_hsv(1500, 4096, 0);
    endtask

    task automatic test_sectors();
        send_hsv(0, 4096, 4096);
        send_hsv(959, 4096, 4096);
        send_hsv(960, 4096, 4096);
        send_hsv(1920, 4096, 4096);
        send_hsv(2880, 4096, 4096);
        send_hsv(3840, 4096, 4096);
        send_hsv(4800, 4096, 4096);
        send_hsv(5759, 4096, 4096);
    endtask

    // value 1.0 must give exactly 255 on the channel carrying c + m
    task automatic test_full_value();
        send_hsv(480, 1234, 4096);
        send_hsv(3000, 4096, 4095);
        send_hsv(2400, 8191, 8191);
    endtask

    task automatic test_random_colors(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_hsv(random_hue(), random_q12(), random_q12());
        end
    endtask

    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_hsv(random_hue(), random_q12(), random_q12());
    endtask

    initial begin
        i_rst_n           = 1'b0;
        hsv_ch.valid      = 1'b0;
        hsv_ch.hue        = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        test_hue_wrap();
        test_sat_val_clamp();
        test_sectors();
        test_full_value();
        test_random_colors(1300);
        test_steady_stream(620);

        hsv_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_rgb.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_if.sv
rtl/hsvrgb_front.sv
rtl/hsvrgb_back.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsvrgb_checker.sv
sim/tb_top.sv
